### rtl/sinsmed_pkg.sv
// Shared constants and types for the sorted-insert median block.
// No dependencies; imported by the cell, the top level and the checker.
package sinsmed_pkg;

  localparam int DEPTH_DEF        = 8;
  localparam int SAMPLE_WIDTH_DEF = 16;

  // Fixed field widths on the stream ports
  localparam int SAMPLE_FW = 16;
  localparam int COUNT_FW  = 4;
  localparam int MEDIAN_FW = 16;
  localparam int IN_DW     = 16;
  localparam int OUT_DW    = 24;

  // tuser op codes
  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Control broadcast from the top level to every cell
  typedef struct packed {
    logic load;   // word accepted this cycle
    logic clear;  // accepted word is a clear
  } cell_ctrl_t;

endpackage

### rtl/sorted_insert_median.sv
// Sorted-insert median: a row of DEPTH compare-and-shift cells keeps the store in order.
// The result word of an accepted input word is in the output register in the next cycle.
// Throughput: 1 word per cycle if not stalled; every cell compares against the broadcast
// sample at once. The output register lets a new word in while the previous result is taken.
// Reset (rst_n low, synchronous): all entries set to the maximum value, count zero, no result.
// Depends on sinsmed_pkg and sinsmed_cell.
module sorted_insert_median #(
  parameter int DEPTH        = sinsmed_pkg::DEPTH_DEF,
  parameter int SAMPLE_WIDTH = sinsmed_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [sinsmed_pkg::IN_DW-1:0] in_tdata,   // [15:0] sample
  input  logic                          in_tuser,   // [0] op
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [sinsmed_pkg::OUT_DW-1:0] out_tdata  // [3:0] fill_count, [19:4] median
);
  import sinsmed_pkg::*;

  localparam int CW  = $clog2(DEPTH + 1);
  localparam int MID = DEPTH / 2;

  cell_ctrl_t              ctrl;
  logic [SAMPLE_WIDTH-1:0] sample;
  logic [DEPTH-1:0]        gt;
  logic [SAMPLE_WIDTH-1:0] entry     [DEPTH];
  logic [SAMPLE_WIDTH-1:0] entry_nxt [DEPTH];

  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 out_valid_r;
  logic [COUNT_FW-1:0]  out_cnt_r;
  logic [MEDIAN_FW-1:0] out_med_r;

  assign in_tready  = !out_valid_r || out_tready;
  assign ctrl.load  = in_tvalid && in_tready;
  assign ctrl.clear = ctrl.load && (in_tuser == OP_CLEAR);
  assign sample     = SAMPLE_WIDTH'(in_tdata[SAMPLE_FW-1:0]);

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic                    lgt;
    logic [SAMPLE_WIDTH-1:0] lent;
    if (k == 0) begin : g_head
      assign lgt  = 1'b0;
      assign lent = sample;
    end else begin : g_body
      assign lgt  = gt[k-1];
      assign lent = entry[k-1];
    end
    sinsmed_cell #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .sample     (sample),
      .left_gt    (lgt),
      .left_entry (lent),
      .gt         (gt[k]),
      .entry      (entry[k]),
      .entry_nxt  (entry_nxt[k])
    );
  end

  // Count saturates at DEPTH; discarded samples still advance it.
  always_comb begin
    cnt_nxt = cnt_r;
    if (ctrl.clear) begin
      cnt_nxt = '0;
    end else if (ctrl.load && (cnt_r < CW'(DEPTH))) begin
      cnt_nxt = cnt_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (ctrl.load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      out_cnt_r <= COUNT_FW'(cnt_nxt);
      out_med_r <= MEDIAN_FW'(entry_nxt[MID]);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DW - COUNT_FW - MEDIAN_FW)'(0), out_med_r, out_cnt_r};

endmodule

### rtl/sinsmed_cell.sv
// One compare-and-shift cell of the sorted store: holds a single entry.
// Depends on sinsmed_pkg for the control struct.
module sinsmed_cell #(
  parameter int SAMPLE_WIDTH = sinsmed_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  sinsmed_pkg::cell_ctrl_t ctrl,
  input  logic [SAMPLE_WIDTH-1:0] sample,
  input  logic                    left_gt,
  input  logic [SAMPLE_WIDTH-1:0] left_entry,
  output logic                    gt,
  output logic [SAMPLE_WIDTH-1:0] entry,
  output logic [SAMPLE_WIDTH-1:0] entry_nxt
);
  import sinsmed_pkg::*;

  logic [SAMPLE_WIDTH-1:0] entry_r;

  assign gt    = sample < entry_r;
  assign entry = entry_r;

  // Take the left neighbor's entry when the insert point is further left,
  // take the sample if it is here, otherwise hold; a clear loads all ones.
  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.clear) begin
      entry_nxt = '1;
    end else if (ctrl.load && gt) begin
      entry_nxt = left_gt ? left_entry : sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '1;
    end else if (ctrl.load) begin
      entry_r <= entry_nxt;
    end
  end

endmodule

### rtl/sinsmed_checker.sv
// Port-level assertions for sorted_insert_median, attached by the bind below.
// Depends on sinsmed_pkg for port widths and op codes.
module sinsmed_assert #(
  parameter int DEPTH = sinsmed_pkg::DEPTH_DEF
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           in_tuser,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [sinsmed_pkg::OUT_DW-1:0] out_tdata
);
  import sinsmed_pkg::*;

  logic in_acc;
  assign in_acc = in_tvalid && in_tready;

  // Every accepted word yields a result word on the next cycle.
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_tvalid)
    else $error("no result word after accepted input word");

  // A clear resets the count seen in its result.
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_tuser == OP_CLEAR)) |=> (out_tdata[COUNT_FW-1:0] == '0))
    else $error("clear result count not zero");

  // An empty output register never blocks the input.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // Count never passes DEPTH.
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((DEPTH > 15) || (out_tdata[COUNT_FW-1:0] <= DEPTH)))
    else $error("fill count above depth");

  // Stalled result word holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result word changed");

endmodule

bind sorted_insert_median sinsmed_assert #(.DEPTH(DEPTH)) u_sinsmed_assert (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

### tb/sinsmed_checker.sv
// Checker for sorted_insert_median: watches both stream channels, predicts each result word
// from its own copy of the sorted store and compares it field by field. Uses sinsmed_pkg.
`timescale 1ns / 100ps

module sinsmed_checker #(
  parameter int DEPTH = sinsmed_pkg::DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [sinsmed_pkg::IN_DW-1:0]  in_tdata,   // [15:0] sample
  input  logic                           in_tuser,   // [0] op
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [sinsmed_pkg::OUT_DW-1:0] out_tdata,  // [3:0] fill_count, [19:4] median
  output int                             fail_count,
  output int                             pending
);
  import sinsmed_pkg::*;

  typedef struct packed {
    logic [COUNT_FW-1:0]  fill_count;
    logic [MEDIAN_FW-1:0] median;
  } median_result_t;

  localparam logic [SAMPLE_FW-1:0] SAMPLE_TOP = '1;

  logic [SAMPLE_FW-1:0] store_model [DEPTH];
  int unsigned          count_model;
  median_result_t       expected_results [$];

  function automatic void empty_store();
    for (int k = 0; k < DEPTH; k++) store_model[k] = SAMPLE_TOP;
    count_model = 0;
  endfunction

  // Apply one input word to the store copy and return the result it produces
  function automatic median_result_t predict_median(logic op, logic [SAMPLE_FW-1:0] sample);
    median_result_t res;
    int pos;
    pos = -1;
    if (op == OP_CLEAR) begin
      empty_store();
    end else begin
      for (int k = 0; k < DEPTH; k++) begin
        if (pos < 0 && sample < store_model[k]) pos = k;
      end
      // shift larger entries up, top one falls off
      if (pos >= 0) begin
        for (int k = DEPTH - 1; k > pos; k--) store_model[k] = store_model[k - 1];
        store_model[pos] = sample;
      end
      if (count_model < DEPTH) count_model++;
    end
    res.fill_count = count_model[COUNT_FW-1:0];
    res.median     = store_model[DEPTH / 2];
    return res;
  endfunction

  always @(posedge clk) begin
    median_result_t want;
    logic [COUNT_FW-1:0]  got_count;
    logic [MEDIAN_FW-1:0] got_median;
    if (!rst_n) begin
      empty_store();
      expected_results.delete();
    end else begin
      // compare first: a word taken now belongs to an earlier input
      if (out_tvalid && out_tready) begin
        got_count  = out_tdata[COUNT_FW-1:0];
        got_median = out_tdata[COUNT_FW +: MEDIAN_FW];
        if (expected_results.size() == 0) begin
          $error("unexpected result word: fill_count %0d median %0d", got_count, got_median);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (got_count !== want.fill_count) begin
            $error("fill_count mismatch: expected %0d, actual %0d", want.fill_count, got_count);
            fail_count++;
          end
          if (got_median !== want.median) begin
            $error("median mismatch: expected %0d, actual %0d", want.median, got_median);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready)
        expected_results.push_back(predict_median(in_tuser, in_tdata[SAMPLE_FW-1:0]));
    end
    pending = expected_results.size();
  end

endmodule

### tb/sorted_insert_median_tb.sv
// Top of the sorted_insert_median testbench: clock, reset, stimulus and verdict.
// Depends on sinsmed_pkg, the block itself and sinsmed_checker.
`timescale 1ns / 100ps

module sorted_insert_median_tb;
  import sinsmed_pkg::*;

  localparam int RANDOM_WORDS = 1650;
  localparam int HOLD_AFTER   = 400;  // result words taken before the long hold-off
  localparam int HOLD_CYCLES  = 60;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [IN_DW-1:0]  in_tdata;   // [15:0] sample
  logic              in_tuser;   // [0] op
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_DW-1:0] out_tdata;  // [3:0] fill_count, [19:4] median
  int                fail_count;
  int                pending;
  bit                sender_idles;
  bit                receiver_idles;
  int                words_taken;

  always #6 clk = ~clk;

  sorted_insert_median dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  sinsmed_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Offer one word after a random gap; return at the falling edge after it is taken
  task automatic send_word(logic op, logic [SAMPLE_FW-1:0] sample);
    int gap;
    gap = sender_idles ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = sample;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic add_sample(logic [SAMPLE_FW-1:0] sample);
    send_word(OP_ADD, sample);
  endtask

  function automatic logic [SAMPLE_FW-1:0] draw_sample();
    logic [SAMPLE_FW-1:0] s;
    case ($urandom_range(0, 9))
      0:       s = '0;
      1:       s = '1;
      2, 3:    s = SAMPLE_FW'($urandom_range(0, 7));  // plenty of ties
      4:       s = SAMPLE_FW'($urandom_range(16'hfff0, 16'hffff));
      default: s = SAMPLE_FW'($urandom());
    endcase
    return s;
  endfunction

  // Receiver: random stalls, stretches without any, and one long hold-off
  initial begin
    int stall;
    out_tready     = 1'b0;
    receiver_idles = 1'b1;
    words_taken    = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (words_taken % 64 == 0) receiver_idles = $urandom_range(0, 3) != 0;
      stall = receiver_idles ? $urandom_range(0, 4) : 0;
      if (words_taken == HOLD_AFTER) stall = HOLD_CYCLES;
      if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      words_taken++;
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = OP_ADD;
    sender_idles = 1'b1;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // directed: maximum into the empty store, extremes, ties, saturation, clears
    add_sample(16'hffff);           // not smaller than any entry: dropped, still counted
    send_word(OP_CLEAR, 16'h1234);  // sample ignored on clear
    add_sample(16'h0000);
    add_sample(16'hfffe);
    add_sample(16'h8000);
    add_sample(16'h8000);           // equal entry: goes after the existing one
    add_sample(16'h0001);
    add_sample(16'h7fff);
    add_sample(16'h0000);
    add_sample(16'h5555);           // store full now
    add_sample(16'haaaa);
    add_sample(16'hffff);           // larger than every entry: dropped, count stays
    add_sample(16'h0002);           // top entry drops out
    add_sample(16'h0000);
    send_word(OP_CLEAR, 16'hffff);
    send_word(OP_CLEAR, 16'h0000);
    repeat (10) add_sample(16'h0003);
    send_word(OP_CLEAR, 16'h0000);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 50 == 0) sender_idles = $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 19) == 0) send_word(OP_CLEAR, SAMPLE_FW'($urandom()));
      else add_sample(draw_sample());
    end
    in_tvalid = 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("simulation failed");
    $finish;
  end

endmodule
